FILE: rtl/bpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_pkg: shared definitions of the bezier point evaluator
// Fixed-point formats, register indexes and the buses between the units.
// ----------------------------------------------------------------------------
package bpe_pkg;

	// coordinate and curve parameter formats
	localparam int COORD_WIDTH     = 16;
	localparam int PARAM_FRAC_BITS = 16;

	localparam int NUM_PTS   = 4;
	localparam int NUM_AXES  = 3;
	localparam int PARAM_W   = PARAM_FRAC_BITS + 1;
	localparam int WGT_W     = PARAM_FRAC_BITS + 1;
	localparam int PT_W      = NUM_AXES * COORD_WIDTH;
	localparam int CFG_IDX_W = 3;

	// 1.0 in the curve parameter format
	localparam logic [PARAM_W-1:0] PARAM_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CUBIC_MODE  = 3'd0,
		REG_POINT_ZERO  = 3'd1,
		REG_POINT_ONE   = 3'd2,
		REG_POINT_TWO   = 3'd3,
		REG_POINT_THREE = 3'd4
	} cfg_reg_t;

	// register file contents
	typedef struct packed {
		logic                           cubic_mode;
		logic [NUM_PTS-1:0][PT_W-1:0]   pts;
	} cfg_t;

	// bernstein weights with their valid bit
	typedef struct packed {
		logic                           valid;
		logic [NUM_PTS-1:0][WGT_W-1:0]  w;
	} wgt_bus_t;

endpackage

FILE: rtl/bpe_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_cfg_regs: configuration register file
// Holds the curve mode and the four packed control points.
// ----------------------------------------------------------------------------
module bpe_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bpe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpe_pkg::PT_W-1:0]          cfg_data,
	output bpe_pkg::cfg_t                     cfg
);

	bpe_pkg::cfg_t cfg_q;

	// a write word is taken every cycle
	assign cfg_ready = 1'b1;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bpe_pkg::REG_CUBIC_MODE: begin
					cfg_q.cubic_mode <= cfg_data[0];
				end
				bpe_pkg::REG_POINT_ZERO: begin
					cfg_q.pts[0] <= cfg_data;
				end
				bpe_pkg::REG_POINT_ONE: begin
					cfg_q.pts[1] <= cfg_data;
				end
				bpe_pkg::REG_POINT_TWO: begin
					cfg_q.pts[2] <= cfg_data;
				end
				bpe_pkg::REG_POINT_THREE: begin
					cfg_q.pts[3] <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/bpe_weight_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_weight_gen: bernstein weight pipeline
// Clamps t, forms the rounded squares, then the quadratic or cubic weights.
// ----------------------------------------------------------------------------
module bpe_weight_gen (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [bpe_pkg::PARAM_W-1:0]       curve_param,
	input  logic                              cubic_mode,
	output bpe_pkg::wgt_bus_t                 wgt
);

	localparam int F     = bpe_pkg::PARAM_FRAC_BITS;
	localparam int PW    = bpe_pkg::PARAM_W;
	localparam int WW    = bpe_pkg::WGT_W;
	localparam int TRI_W = PW + 1;
	localparam int SQ_W  = 2 * PW;
	localparam int CUB_W = WW + TRI_W;

	localparam logic [SQ_W+1:0]  SQ_HALF  = (SQ_W+2)'(1) << (F - 1);
	localparam logic [CUB_W:0]   CUB_HALF = (CUB_W+1)'(1) << (F - 1);

	// stage 1 registers
	logic             valid_s1;
	logic [PW-1:0]    a_s1;
	logic [PW-1:0]    b_s1;

	// stage 2 registers
	logic             valid_s2;
	logic [PW-1:0]    a_s2;
	logic [PW-1:0]    b_s2;
	logic [TRI_W-1:0] a3_s2;
	logic [TRI_W-1:0] b3_s2;
	logic [WW-1:0]    a2_s2;
	logic [WW-1:0]    b2_s2;
	logic [WW-1:0]    ab2_s2;

	// stage 3 registers
	logic                                 valid_s3;
	logic [bpe_pkg::NUM_PTS-1:0][WW-1:0]  w_s3;

	logic [PW-1:0]    a_clamp;
	logic [SQ_W-1:0]  aa;
	logic [SQ_W-1:0]  bb;
	logic [SQ_W-1:0]  ab;
	logic [SQ_W+1:0]  aa_rnd;
	logic [SQ_W+1:0]  bb_rnd;
	logic [SQ_W+1:0]  ab2_rnd;
	logic [CUB_W-1:0] p0;
	logic [CUB_W-1:0] p1;
	logic [CUB_W-1:0] p2;
	logic [CUB_W-1:0] p3;
	logic [CUB_W:0]   p0_rnd;
	logic [CUB_W:0]   p1_rnd;
	logic [CUB_W:0]   p2_rnd;
	logic [CUB_W:0]   p3_rnd;
	logic [bpe_pkg::NUM_PTS-1:0][WW-1:0]  w_next;

	// t above one saturates to one
	assign a_clamp = (curve_param > bpe_pkg::PARAM_ONE) ? bpe_pkg::PARAM_ONE : curve_param;

	// stage 1: clamp and complement
	always_ff @(posedge clk) begin
		a_s1 <= a_clamp;
		b_s1 <= bpe_pkg::PARAM_ONE - a_clamp;
	end

	// stage 2 math: squares and cross term, rounded half up
	assign aa      = a_s1 * a_s1;
	assign bb      = b_s1 * b_s1;
	assign ab      = a_s1 * b_s1;
	assign aa_rnd  = (SQ_W+2)'(aa) + SQ_HALF;
	assign bb_rnd  = (SQ_W+2)'(bb) + SQ_HALF;
	assign ab2_rnd = {1'b0, ab, 1'b0} + SQ_HALF;

	always_ff @(posedge clk) begin
		a_s2   <= a_s1;
		b_s2   <= b_s1;
		a3_s2  <= {a_s1, 1'b0} + TRI_W'(a_s1);
		b3_s2  <= {b_s1, 1'b0} + TRI_W'(b_s1);
		a2_s2  <= aa_rnd[F +: WW];
		b2_s2  <= bb_rnd[F +: WW];
		ab2_s2 <= ab2_rnd[F +: WW];
	end

	// stage 3 math: cubic terms from the rounded squares
	assign p0     = b2_s2 * b_s2;
	assign p1     = a3_s2 * b2_s2;
	assign p2     = a2_s2 * b3_s2;
	assign p3     = a2_s2 * a_s2;
	assign p0_rnd = (CUB_W+1)'(p0) + CUB_HALF;
	assign p1_rnd = (CUB_W+1)'(p1) + CUB_HALF;
	assign p2_rnd = (CUB_W+1)'(p2) + CUB_HALF;
	assign p3_rnd = (CUB_W+1)'(p3) + CUB_HALF;

	// weight select by curve order
	always_comb begin
		if (cubic_mode) begin
			w_next[0] = p0_rnd[F +: WW];
			w_next[1] = p1_rnd[F +: WW];
			w_next[2] = p2_rnd[F +: WW];
			w_next[3] = p3_rnd[F +: WW];
		end else begin
			w_next[0] = b2_s2;
			w_next[1] = ab2_s2;
			w_next[2] = a2_s2;
			w_next[3] = '0;
		end
	end

	always_ff @(posedge clk) begin
		w_s3 <= w_next;
	end

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign wgt.valid = valid_s3;
	assign wgt.w     = w_s3;

endmodule

FILE: rtl/bpe_axis_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_axis_blend: weighted sum of one coordinate axis
// Multiplies the control coordinates by the weights, adds, rounds, saturates.
// ----------------------------------------------------------------------------
module bpe_axis_blend (
	input  logic                                                      clk,
	input  logic                                                      arst_n,
	input  bpe_pkg::wgt_bus_t                                         wgt,
	input  logic [bpe_pkg::NUM_PTS-1:0][bpe_pkg::COORD_WIDTH-1:0]     coords,
	output logic                                                      out_valid,
	output logic [bpe_pkg::COORD_WIDTH-1:0]                           coord_out
);

	localparam int F      = bpe_pkg::PARAM_FRAC_BITS;
	localparam int CW     = bpe_pkg::COORD_WIDTH;
	localparam int PROD_W = CW + bpe_pkg::WGT_W;
	localparam int PAIR_W = PROD_W + 1;
	localparam int SUM_W  = PROD_W + 3;

	localparam logic signed [SUM_W-1:0] SUM_HALF  = SUM_W'(1) << (F - 1);
	localparam logic signed [SUM_W-1:0] COORD_MAX = SUM_W'((1 << (CW - 1)) - 1);
	localparam logic signed [SUM_W-1:0] COORD_MIN = SUM_W'(-(1 << (CW - 1)));

	logic                                         valid_s4;
	logic                                         valid_s5;
	logic                                         valid_s6;
	logic                                         valid_s7;
	logic signed [bpe_pkg::NUM_PTS-1:0][PROD_W-1:0] prod_s4;
	logic signed [PAIR_W-1:0]                     pair0_s5;
	logic signed [PAIR_W-1:0]                     pair1_s5;
	logic signed [SUM_W-1:0]                      sum_s6;
	logic [CW-1:0]                                coord_s7;

	logic signed [SUM_W-1:0]                      shifted;
	logic [CW-1:0]                                sat;

	// stage 4: one product per control point
	always_ff @(posedge clk) begin
		for (int i = 0; i < bpe_pkg::NUM_PTS; i++) begin
			prod_s4[i] <= $signed(coords[i]) * $signed({1'b0, wgt.w[i]});
		end
	end

	// stage 5: pairwise sums
	always_ff @(posedge clk) begin
		pair0_s5 <= PAIR_W'($signed(prod_s4[0])) + PAIR_W'($signed(prod_s4[1]));
		pair1_s5 <= PAIR_W'($signed(prod_s4[2])) + PAIR_W'($signed(prod_s4[3]));
	end

	// stage 6: total plus rounding half
	always_ff @(posedge clk) begin
		sum_s6 <= SUM_W'(pair0_s5) + SUM_W'(pair1_s5) + SUM_HALF;
	end

	// floor shift then clip to the coordinate range
	assign shifted = sum_s6 >>> F;

	always_comb begin
		if (shifted > COORD_MAX) begin
			sat = COORD_MAX[CW-1:0];
		end else if (shifted < COORD_MIN) begin
			sat = COORD_MIN[CW-1:0];
		end else begin
			sat = shifted[CW-1:0];
		end
	end

	// stage 7: output register
	always_ff @(posedge clk) begin
		coord_s7 <= sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s4 <= wgt.valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	assign out_valid = valid_s7;
	assign coord_out = coord_s7;

endmodule

FILE: rtl/bezier_point_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_point_evaluator: quadratic or cubic 3d bezier point per t
// Each accepted start reaches the done strobe through the pipeline stages below.
// Throughput: one t per cycle; busy stays low, the seven stage pipeline
// (weights in three stages, per-axis multiply, two adds, clip) never stalls.
// Reset clears the valid bits and all configuration registers to zero.
// Configuration words are taken every cycle (cfg_ready high).
// ----------------------------------------------------------------------------
module bezier_point_evaluator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [bpe_pkg::PARAM_W-1:0]         curve_param,
	output logic                                done,
	output logic signed [bpe_pkg::COORD_WIDTH-1:0] point_x,
	output logic signed [bpe_pkg::COORD_WIDTH-1:0] point_y,
	output logic signed [bpe_pkg::COORD_WIDTH-1:0] point_z,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bpe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bpe_pkg::PT_W-1:0]            cfg_data
);

	localparam int CW = bpe_pkg::COORD_WIDTH;

	bpe_pkg::cfg_t                                cfg;
	bpe_pkg::wgt_bus_t                            wgt;
	logic [bpe_pkg::NUM_AXES-1:0]                 axis_valid;
	logic [bpe_pkg::NUM_AXES-1:0][CW-1:0]         axis_coord;

	// pipeline always has room
	assign busy = 1'b0;

	// register file
	bpe_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// weight stages
	bpe_weight_gen u_wgt (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start & ~busy),
		.curve_param (curve_param),
		.cubic_mode  (cfg.cubic_mode),
		.wgt         (wgt)
	);

	// one blend unit per axis
	for (genvar ax = 0; ax < bpe_pkg::NUM_AXES; ax++) begin : g_axis
		logic [bpe_pkg::NUM_PTS-1:0][CW-1:0] coords;

		always_comb begin
			for (int i = 0; i < bpe_pkg::NUM_PTS; i++) begin
				coords[i] = cfg.pts[i][ax*CW +: CW];
			end
		end

		bpe_axis_blend u_blend (
			.clk       (clk),
			.arst_n    (arst_n),
			.wgt       (wgt),
			.coords    (coords),
			.out_valid (axis_valid[ax]),
			.coord_out (axis_coord[ax])
		);
	end

	// result word
	assign done    = axis_valid[0];
	assign point_x = axis_coord[0];
	assign point_y = axis_coord[1];
	assign point_z = axis_coord[2];

	// a result always comes from an accepted start that went through the pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 7))
		else $error("done without a matching start");

	// the three axis pipelines stay in lock step
	assert property (@(posedge clk) disable iff (!arst_n)
		(axis_valid[1] == axis_valid[0]) && (axis_valid[2] == axis_valid[0]))
		else $error("axis valid bits out of step");

	// quadratic curves never weight the fourth point
	assert property (@(posedge clk) disable iff (!arst_n)
		(wgt.valid && !cfg.cubic_mode) |-> (wgt.w[3] == '0))
		else $error("fourth weight set in quadratic mode");

endmodule

FILE: tb/sv/bpe_point_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_point_checker: scoreboard of the bezier point evaluator
// Mirrors every configuration word, predicts the curve point of each accepted
// curve parameter and compares every done word field by field, oldest first.
// ----------------------------------------------------------------------------
module bpe_point_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic [bpe_pkg::PARAM_W-1:0]            curve_param,
	input  logic                                   done,
	input  logic signed [bpe_pkg::COORD_WIDTH-1:0] point_x,
	input  logic signed [bpe_pkg::COORD_WIDTH-1:0] point_y,
	input  logic signed [bpe_pkg::COORD_WIDTH-1:0] point_z,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [bpe_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [bpe_pkg::PT_W-1:0]               cfg_data,
	output int                                     mismatch_count,
	output int                                     points_in_flight
);
	import bpe_pkg::*;

	localparam longint unsigned T_ONE  = 64'd1 << PARAM_FRAC_BITS;
	localparam longint unsigned T_HALF = 64'd1 << (PARAM_FRAC_BITS - 1);
	localparam longint COORD_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
	localparam longint COORD_LO = -(64'sd1 <<< (COORD_WIDTH - 1));
	localparam int MAX_REPORTS = 10;

	// one predicted point together with the t that produced it
	typedef struct packed {
		logic [PARAM_W-1:0]     t;
		logic [COORD_WIDTH-1:0] x;
		logic [COORD_WIDTH-1:0] y;
		logic [COORD_WIDTH-1:0] z;
	} curve_point_t;

	logic            cubic_curve;
	logic [PT_W-1:0] ctrl_pts [NUM_PTS];
	curve_point_t    expected_points [$];
	int              failures;

	// round a fraction with PARAM_FRAC_BITS fractional bits, half up
	function automatic longint unsigned round_frac(input longint unsigned v);
		return (v + T_HALF) >> PARAM_FRAC_BITS;
	endfunction

	// bernstein weighted sum of the control points at parameter t
	function automatic curve_point_t predict_point(input logic [PARAM_W-1:0] t);
		longint unsigned a, b, a2, b2;
		longint unsigned wgt [NUM_PTS];
		longint acc;
		logic signed [COORD_WIDTH-1:0] coord;
		logic [COORD_WIDTH-1:0] res [NUM_AXES];
		curve_point_t p;
		int axis, i;
		a = t;
		if (a > T_ONE)
			a = T_ONE;
		b = T_ONE - a;
		if (cubic_curve) begin
			b2 = round_frac(b * b);
			a2 = round_frac(a * a);
			wgt[0] = round_frac(b2 * b);
			wgt[1] = round_frac(3 * a * b2);
			wgt[2] = round_frac(3 * a2 * b);
			wgt[3] = round_frac(a2 * a);
		end else begin
			wgt[0] = round_frac(b * b);
			wgt[1] = round_frac(2 * a * b);
			wgt[2] = round_frac(a * a);
			wgt[3] = 0;
		end
		for (axis = 0; axis < NUM_AXES; axis++) begin
			acc = 0;
			for (i = 0; i < NUM_PTS; i++) begin
				coord = ctrl_pts[i][axis*COORD_WIDTH +: COORD_WIDTH];
				acc += longint'(coord) * longint'(wgt[i]);
			end
			// floor after adding half, then clip to the coordinate range
			acc = (acc + longint'(T_HALF)) >>> PARAM_FRAC_BITS;
			if (acc > COORD_HI)
				acc = COORD_HI;
			if (acc < COORD_LO)
				acc = COORD_LO;
			res[axis] = acc[COORD_WIDTH-1:0];
		end
		p.t = t;
		p.x = res[0];
		p.y = res[1];
		p.z = res[2];
		return p;
	endfunction

	// count a wrong coordinate, report only the first few
	task automatic check_coord(input string axis, input logic [PARAM_W-1:0] t,
			input logic [COORD_WIDTH-1:0] want, input logic [COORD_WIDTH-1:0] got);
		if (got !== want) begin
			failures++;
			if (failures <= MAX_REPORTS)
				$display("%0t: %s mismatch at t=%h: expected %0d, got %0d",
					$time, axis, t, $signed(want), $signed(got));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		curve_point_t want;
		if (!arst_n) begin
			cubic_curve = 1'b0;
			for (int k = 0; k < NUM_PTS; k++)
				ctrl_pts[k] = '0;
			expected_points.delete();
			failures = 0;
			mismatch_count <= 0;
			points_in_flight <= 0;
		end else begin
			// configuration word
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CUBIC_MODE:  cubic_curve = cfg_data[0];
					REG_POINT_ZERO:  ctrl_pts[0] = cfg_data;
					REG_POINT_ONE:   ctrl_pts[1] = cfg_data;
					REG_POINT_TWO:   ctrl_pts[2] = cfg_data;
					REG_POINT_THREE: ctrl_pts[3] = cfg_data;
					default: ;
				endcase
			end

			// done word against the oldest prediction
			if (done) begin
				if (expected_points.size() == 0) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("%0t: done word with nothing expected: x %0d y %0d z %0d",
							$time, point_x, point_y, point_z);
				end else begin
					want = expected_points.pop_front();
					check_coord("x", want.t, want.x, point_x);
					check_coord("y", want.t, want.y, point_y);
					check_coord("z", want.t, want.z, point_z);
				end
			end

			// accepted curve parameter
			if (start && !busy)
				expected_points.push_back(predict_point(curve_param));

			mismatch_count <= failures;
			points_in_flight <= expected_points.size();
		end
	end

endmodule

FILE: tb/sv/bezier_point_evaluator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_point_evaluator_tb: testbench of the bezier point evaluator
// Directed t values at the range edges in both curve modes, then random
// curve parameters over several control point sets with random start gaps.
// The checker beside the block predicts and compares every point.
// ----------------------------------------------------------------------------
module bezier_point_evaluator_tb;
	import bpe_pkg::*;

	localparam int T_ONE         = 1 << PARAM_FRAC_BITS;
	localparam int T_MAX         = (1 << PARAM_W) - 1;
	localparam int LATENCY       = 7;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 100;
	localparam logic [CFG_IDX_W-1:0]   IDX_TOP = '1;
	localparam logic [COORD_WIDTH-1:0] C_MAX   = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] C_MIN   = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// how the coordinates of a control point set are drawn
	typedef enum int {
		PT_RANDOM,
		PT_ALL_MAX,
		PT_ALL_MIN,
		PT_EXTREMES
	} pt_kind_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [PARAM_W-1:0]            curve_param;
	logic                          done;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [PT_W-1:0]               cfg_data;
	int                            mismatch_count;
	int                            points_in_flight;
	int                            cycle_count = 0;

	bezier_point_evaluator u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.curve_param (curve_param),
		.done        (done),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	bpe_point_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.curve_param      (curve_param),
		.done             (done),
		.point_x          (point_x),
		.point_y          (point_y),
		.point_z          (point_z),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mismatch_count   (mismatch_count),
		.points_in_flight (points_in_flight)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [COORD_WIDTH-1:0] rand_coord(input pt_kind_t kind);
		case (kind)
			PT_ALL_MAX: return C_MAX;
			PT_ALL_MIN: return C_MIN;
			PT_EXTREMES: begin
				case ($urandom_range(3, 0))
					0: return C_MAX;
					1: return C_MIN;
					2: return '0;
					default: return COORD_WIDTH'($urandom);
				endcase
			end
			default: return COORD_WIDTH'($urandom);
		endcase
	endfunction

	function automatic logic [PT_W-1:0] rand_point(input pt_kind_t kind);
		return {rand_coord(kind), rand_coord(kind), rand_coord(kind)};
	endfunction

	// mostly inside [0, 1], some clamped, some at the ends
	function automatic logic [PARAM_W-1:0] rand_param();
		case ($urandom_range(9, 0))
			0: return PARAM_W'($urandom_range(T_MAX, T_ONE));
			1: return PARAM_W'($urandom);
			2: begin
				if ($urandom_range(1, 0))
					return PARAM_W'($urandom_range(T_ONE + 2, T_ONE - 2));
				return PARAM_W'($urandom_range(2, 0));
			end
			default: return PARAM_W'($urandom_range(T_ONE, 0));
		endcase
	endfunction

	// one configuration word; valid stays up for a following word
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// full register set, preceded by a write to an unmapped index
	task automatic configure(input logic cubic, input logic [PT_W-1:0] p0,
			input logic [PT_W-1:0] p1, input logic [PT_W-1:0] p2, input logic [PT_W-1:0] p3);
		write_reg(CFG_IDX_W'($urandom_range(int'(IDX_TOP), int'(REG_POINT_THREE) + 1)),
			{16'($urandom), 32'($urandom)});
		write_reg(REG_CUBIC_MODE, {15'($urandom), 32'($urandom), cubic});
		write_reg(REG_POINT_ZERO, p0);
		write_reg(REG_POINT_ONE, p1);
		write_reg(REG_POINT_TWO, p2);
		write_reg(REG_POINT_THREE, p3);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// one curve parameter after a random gap; start stays up for a following word
	task automatic send_param(input logic [PARAM_W-1:0] t, input int idle_pct);
		while ($urandom_range(99, 0) < idle_pct) begin
			start       <= 1'b0;
			curve_param <= PARAM_W'($urandom);
			@(posedge clk);
		end
		start       <= 1'b1;
		curve_param <= t;
		do @(posedge clk); while (busy);
	endtask

	// stop sending and let every outstanding point come back
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (points_in_flight != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// stimulus
	initial begin
		logic [PARAM_W-1:0] edge_params [10];
		int idle_pct;
		int ph, n;
		start       <= 1'b0;
		curve_param <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= REG_CUBIC_MODE;
		cfg_data    <= '0;
		arst_n      <= 1'b0;
		edge_params = '{
			'0, PARAM_W'(1), PARAM_ONE >> 1, PARAM_ONE - 1'b1, PARAM_ONE,
			PARAM_ONE + 1'b1, {PARAM_W{1'b1}}, PARAM_W'(21845), PARAM_W'(43690),
			PARAM_W'(87381)
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// quadratic at the range edges; point three holds junk and is ignored
		configure(1'b0, {C_MIN, C_MIN, C_MAX}, {C_MAX, C_MIN, C_MAX},
			{C_MAX, C_MAX, C_MIN}, rand_point(PT_RANDOM));
		foreach (edge_params[k])
			send_param(edge_params[k], 0);
		drain();

		// cubic with coordinates at the extremes, weight overshoot saturates
		configure(1'b1, {C_MIN, C_MIN, C_MAX}, {C_MAX, C_MIN, C_MAX},
			{C_MIN, C_MIN, C_MAX}, {C_MAX, C_MIN, C_MAX});
		foreach (edge_params[k])
			send_param(edge_params[k], 0);
		drain();

		// random phases: each point pattern in both modes, three gap regimes
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			idle_pct = (ph < 3) ? 14 : (ph < 6) ? 76 : 0;
			configure(ph >= RANDOM_PHASES / 2,
				rand_point(pt_kind_t'(ph % 4)), rand_point(pt_kind_t'(ph % 4)),
				rand_point(pt_kind_t'(ph % 4)), rand_point(pt_kind_t'(ph % 4)));
			for (n = 0; n < PHASE_ITEMS; n++)
				send_param(rand_param(), idle_pct);
			drain();
		end

		if (mismatch_count == 0 && points_in_flight == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
